// ----- rtl/i2c_scl_divisor_search_defines.svh -----
// assertion macros used by the bound checker file
`ifndef I2C_SCL_DIVISOR_SEARCH_DEFINES_SVH
`define I2C_SCL_DIVISOR_SEARCH_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define I2CSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2CSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i2csd_pkg.sv -----
package i2csd_pkg;

    localparam int DIV_W    = 29;
    localparam int REQ_W    = 24;
    localparam int TGT_W    = 19;
    localparam int RATE_W   = 25;
    localparam int COARSE_W = 2;
    localparam int FINE_W   = 6;

    localparam logic [TGT_W-1:0] CLAMP_HZ    = 19'd384600;
    localparam logic [TGT_W-1:0] LOW_HZ      = 19'd90000;
    localparam logic [TGT_W-1:0] FALLBACK_HZ = 19'd100000;
    localparam logic [DIV_W-1:0] SRC_RESET_HZ = 29'd100000000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

    // times 22 as shift and add
    function automatic logic [DIV_W-1:0] mul_prescale(input logic [DIV_W-1:0] x);
        return (x << 4) + (x << 2) + (x << 1);
    endfunction

    // clamp high rates, pull the 90..100 kHz band down to 90 kHz
    function automatic logic [TGT_W-1:0] adjust_target(input logic [REQ_W-1:0] hz);
        logic [TGT_W-1:0] t;
        if (hz > REQ_W'(CLAMP_HZ)) begin
            t = CLAMP_HZ;
        end else begin
            t = hz[TGT_W-1:0];
        end
        if (t <= FALLBACK_HZ && t > LOW_HZ) begin
            t = LOW_HZ;
        end
        return t;
    endfunction

endpackage

// ----- rtl/i2csd_div.sv -----
module i2csd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2csd_pkg::t_div_req i_req,
    output i2csd_pkg::t_div_rsp o_rsp
);
    import i2csd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quot;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;
    logic             q_bit;

    // one restoring step per cycle
    always_comb begin
        rem_sh = {r_rem, r_quot[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        q_bit  = ~diff[DIV_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= q_bit ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quot <= {r_quot[DIV_W-2:0], q_bit};
        end
    end

    assign o_rsp = '{done: r_done, quot: r_quot, rem: r_rem};

endmodule

// ----- rtl/i2c_scl_divisor_search.sv -----
// a search is set by one shared 29-step restoring divider: each candidate needs one divide
// for its coarse value and, when that fits, one for its rate, with a single pass when the
// target divides the source, plus quotient (nonzero request only), remainder and final
// divides; a refused request is answered without the divider
// throughput: one item at a time, a search holds busy high until the result strobe; no stall on output
// reset: synchronous active-low, returns to idle and reloads the source clock with 100 MHz
module i2c_scl_divisor_search #(
    parameter int FINE_STEPS = 64,
    parameter int COARSE_MAX = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [i2csd_pkg::REQ_W-1:0]       i_requested_hz,
    input  logic                              i_transfer_active,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [i2csd_pkg::DIV_W-1:0]       i_cfg_data,
    output logic                              o_strobe,
    output logic                              o_rejected,
    output logic [i2csd_pkg::COARSE_W-1:0]    o_coarse_divisor,
    output logic [i2csd_pkg::FINE_W-1:0]      o_fine_divisor,
    output logic [i2csd_pkg::RATE_W-1:0]      o_achieved_hz,
    output logic [i2csd_pkg::TGT_W-1:0]       o_best_error_hz
);
    import i2csd_pkg::*;

    // fine counter, coarse value and divisor product widths
    localparam int BW  = $clog2(FINE_STEPS);
    localparam int CW  = $clog2(COARSE_MAX + 1);
    localparam int PW  = CW + BW + 2;
    localparam int BXW = (BW > FINE_W) ? BW : FINE_W;
    localparam int CXW = (CW > COARSE_W) ? CW : COARSE_W;

    // sequencer states
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,  // wait for start
        S_QW    = 12'b0000_0000_0010,  // base quotient source / (22 * request)
        S_MOD   = 12'b0000_0000_0100,  // issue source % (22 * target)
        S_MODW  = 12'b0000_0000_1000,  // decide on a second quotient
        S_CINIT = 12'b0000_0001_0000,  // open a quotient pass
        S_A     = 12'b0000_0010_0000,  // issue quotient / (fine + 1)
        S_AW    = 12'b0000_0100_0000,  // derive coarse value
        S_PROD  = 12'b0000_1000_0000,  // (coarse + 1) * (fine + 1)
        S_RDIV  = 12'b0001_0000_0000,  // issue source / (22 * product)
        S_RW    = 12'b0010_0000_0000,  // rate back: score or finish
        S_NEXT  = 12'b0100_0000_0000,  // step the fine divisor
        S_QEND  = 12'b1000_0000_0000   // close a quotient pass
    } t_state;

    t_state              r_state;
    t_state              n_state;

    // configuration
    logic [DIV_W-1:0]    r_src;

    // search context
    logic [REQ_W-1:0]    r_req;
    logic [TGT_W-1:0]    r_tgt;
    logic [RATE_W-1:0]   r_q;
    logic                r_second;
    logic                r_final;
    logic [BW-1:0]       r_b;
    logic [CW-1:0]       r_a;
    logic [PW-1:0]       r_prod;

    // best within the current pass, and overall
    logic [TGT_W-1:0]    r_last;
    logic [CW-1:0]       r_ca;
    logic [BW-1:0]       r_cb;
    logic [TGT_W-1:0]    r_best_err;
    logic [CW-1:0]       r_best_a;
    logic [BW-1:0]       r_best_b;

    // result register
    logic                r_strobe;
    logic                r_rejected;
    logic [COARSE_W-1:0] r_out_coarse;
    logic [FINE_W-1:0]   r_out_fine;
    logic [RATE_W-1:0]   r_out_ach;
    logic [TGT_W-1:0]    r_out_err;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic                accept;
    logic                search;
    logic [DIV_W-1:0]    a_full;
    logic [DIV_W-1:0]    a_m;
    logic                a_fits;
    logic [RATE_W-1:0]   rate;
    logic [RATE_W-1:0]   tgt_x;
    logic [RATE_W-1:0]   err;
    logic                err_better;
    logic [CW-1:0]       f_a;
    logic [BW-1:0]       f_b;
    logic [CW:0]         a_inc;
    logic [BW:0]         b_inc;
    logic [CXW-1:0]      coarse_x;
    logic [BXW-1:0]      fine_x;

    assign busy        = (r_state != S_IDLE);
    // source clock only changes when no request is being taken in the same cycle
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign accept      = start && !busy;
    // a refused request never reaches the divider
    assign search      = accept && !i_transfer_active;

    // coarse value: quotient over fine step, minus one unless already zero
    always_comb begin
        a_full = div_rsp.quot;
        a_m    = (a_full != '0) ? a_full - DIV_W'(1) : '0;
        a_fits = (a_m <= DIV_W'(COARSE_MAX));
    end

    // distance of the candidate rate from the target
    always_comb begin
        rate       = div_rsp.quot[RATE_W-1:0];
        tgt_x      = RATE_W'(r_tgt);
        err        = (rate > tgt_x) ? rate - tgt_x : tgt_x - rate;
        err_better = (RATE_W'(r_last) > err);
    end

    // product operands: the candidate, or the winner on the final divide
    always_comb begin
        f_a   = r_final ? r_best_a : r_a;
        f_b   = r_final ? r_best_b : r_b;
        a_inc = {1'b0, f_a} + 1'b1;
        b_inc = {1'b0, f_b} + 1'b1;
    end

    assign coarse_x = CXW'(r_best_a);
    assign fine_x   = BXW'(r_best_b);

    // requests to the shared divider
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_src;
        div_req.divisor  = mul_prescale(DIV_W'(r_tgt));
        unique case (r_state)
            S_IDLE: begin
                div_req.start   = search && (i_requested_hz != '0);
                div_req.divisor = mul_prescale(DIV_W'(i_requested_hz));
            end
            S_MOD: begin
                div_req.start = 1'b1;
            end
            S_A: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(r_q);
                div_req.divisor  = DIV_W'(r_b) + DIV_W'(1);
            end
            S_RDIV: begin
                div_req.start   = 1'b1;
                div_req.divisor = mul_prescale(DIV_W'(r_prod));
            end
            default: begin
            end
        endcase
    end

    i2csd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (search) begin
                    n_state = (i_requested_hz == '0) ? S_MOD : S_QW;
                end
            end
            S_QW: begin
                if (div_rsp.done) begin
                    n_state = S_MOD;
                end
            end
            S_MOD:   n_state = S_MODW;
            S_MODW: begin
                if (div_rsp.done) begin
                    n_state = S_CINIT;
                end
            end
            S_CINIT: n_state = S_A;
            S_A:     n_state = S_AW;
            S_AW: begin
                if (div_rsp.done) begin
                    n_state = a_fits ? S_PROD : S_NEXT;
                end
            end
            S_PROD:  n_state = S_RDIV;
            S_RDIV:  n_state = S_RW;
            S_RW: begin
                if (div_rsp.done) begin
                    n_state = r_final ? S_IDLE : S_NEXT;
                end
            end
            S_NEXT: begin
                n_state = (r_b == BW'(FINE_STEPS - 1)) ? S_QEND : S_A;
            end
            S_QEND: begin
                n_state = r_second ? S_CINIT : S_PROD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_src    <= SRC_RESET_HZ;
            r_strobe <= 1'b0;
            r_second <= 1'b0;
            r_final  <= 1'b0;
            r_b      <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_src <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_final  <= 1'b0;
                        r_strobe <= i_transfer_active;
                    end
                end
                S_MODW: begin
                    if (div_rsp.done) begin
                        // second pass only when the target does not divide the source
                        r_second <= (div_rsp.rem != '0);
                    end
                end
                S_CINIT: r_b <= '0;
                S_NEXT:  r_b <= r_b + BW'(1);
                S_QEND: begin
                    if (r_second) begin
                        r_second <= 1'b0;
                    end else begin
                        r_final <= 1'b1;
                    end
                end
                S_RW: begin
                    if (div_rsp.done && r_final) begin
                        r_strobe <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_req <= i_requested_hz;
                    r_q   <= '0;
                    // zero request goes straight to the fallback rate
                    r_tgt <= adjust_target(REQ_W'(FALLBACK_HZ));
                    if (i_transfer_active) begin
                        r_rejected   <= 1'b1;
                        r_out_coarse <= '0;
                        r_out_fine   <= '0;
                        r_out_ach    <= '0;
                        r_out_err    <= '0;
                    end
                end
            end
            S_QW: begin
                if (div_rsp.done) begin
                    r_q <= div_rsp.quot[RATE_W-1:0];
                    // unreachable request falls back as well
                    if (div_rsp.quot == '0) begin
                        r_tgt <= adjust_target(REQ_W'(FALLBACK_HZ));
                    end else begin
                        r_tgt <= adjust_target(r_req);
                    end
                end
            end
            S_MODW: begin
                if (div_rsp.done) begin
                    r_best_err <= r_tgt;
                    r_best_a   <= '0;
                    r_best_b   <= '0;
                end
            end
            S_CINIT: begin
                r_last <= r_tgt;
                r_ca   <= '0;
                r_cb   <= '0;
            end
            S_AW: begin
                if (div_rsp.done) begin
                    r_a <= a_m[CW-1:0];
                end
            end
            S_PROD: begin
                r_prod <= PW'(a_inc) * PW'(b_inc);
            end
            S_RW: begin
                if (div_rsp.done) begin
                    if (r_final) begin
                        r_rejected   <= 1'b0;
                        r_out_coarse <= coarse_x[COARSE_W-1:0];
                        r_out_fine   <= fine_x[FINE_W-1:0];
                        r_out_ach    <= rate;
                        r_out_err    <= r_best_err;
                    end else if (err_better) begin
                        // first strictly smaller error wins
                        r_last <= err[TGT_W-1:0];
                        r_ca   <= r_a;
                        r_cb   <= r_b;
                    end
                end
            end
            S_QEND: begin
                if (r_last < r_best_err) begin
                    r_best_err <= r_last;
                    r_best_a   <= r_ca;
                    r_best_b   <= r_cb;
                end
                if (r_second) begin
                    r_q <= r_q + RATE_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_strobe         = r_strobe;
    assign o_rejected       = r_rejected;
    assign o_coarse_divisor = r_out_coarse;
    assign o_fine_divisor   = r_out_fine;
    assign o_achieved_hz    = r_out_ach;
    assign o_best_error_hz  = r_out_err;

endmodule

// ----- rtl/i2csd_chk.sv -----
`include "i2c_scl_divisor_search_defines.svh"

module i2csd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              i_transfer_active,
    input logic                              o_strobe,
    input logic                              o_rejected,
    input logic [i2csd_pkg::COARSE_W-1:0]    o_coarse_divisor,
    input logic [i2csd_pkg::FINE_W-1:0]      o_fine_divisor,
    input logic [i2csd_pkg::RATE_W-1:0]      o_achieved_hz,
    input logic [i2csd_pkg::TGT_W-1:0]       o_best_error_hz
);
    import i2csd_pkg::*;

    // refused request answers on the next cycle
    `I2CSD_ASSERT_NEXT(a_reject_next, i_clk, i_rst_n,
        start && !busy && i_transfer_active,
        o_strobe && o_rejected, "refused request not answered at once")

    // a search keeps the block busy and silent on the next cycle
    `I2CSD_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n,
        start && !busy && !i_transfer_active,
        busy && !o_strobe, "search did not hold busy")

    // refused result carries zero fields
    `I2CSD_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, o_strobe && o_rejected,
        {o_coarse_divisor, o_fine_divisor, o_achieved_hz, o_best_error_hz} == '0,
        "refused result has nonzero fields")

    // error never exceeds the clamped target, and the block is free when it reports
    `I2CSD_ASSERT_NOW(a_err_bound, i_clk, i_rst_n, o_strobe && !o_rejected,
        o_best_error_hz <= CLAMP_HZ && !busy, "error above clamp or busy on result")

endmodule

bind i2c_scl_divisor_search i2csd_chk u_i2csd_chk (.*);

// ----- dv/divisor_search_checker.sv -----
module divisor_search_checker #(
    parameter int FINE_STEPS = 64,
    parameter int COARSE_MAX = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [i2csd_pkg::REQ_W-1:0]       i_requested_hz,
    input  logic                              i_transfer_active,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [i2csd_pkg::DIV_W-1:0]       i_cfg_data,
    input  logic                              i_strobe,
    input  logic                              i_rejected,
    input  logic [i2csd_pkg::COARSE_W-1:0]    i_coarse_divisor,
    input  logic [i2csd_pkg::FINE_W-1:0]      i_fine_divisor,
    input  logic [i2csd_pkg::RATE_W-1:0]      i_achieved_hz,
    input  logic [i2csd_pkg::TGT_W-1:0]       i_best_error_hz,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_results,
    output int                                o_refused
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2csd_pkg::*;

    localparam longint unsigned PRESCALE = 22;

    typedef struct packed {
        logic                rejected;
        logic [COARSE_W-1:0] coarse;
        logic [FINE_W-1:0]   fine;
        logic [RATE_W-1:0]   achieved;
        logic [TGT_W-1:0]    error;
    } t_divisor_choice;

    t_divisor_choice  choice_q[$];
    logic [DIV_W-1:0] source_hz;
    int               fail_count = 0;
    int               result_count = 0;
    int               refused_count = 0;

    assign o_fail_count = fail_count;
    assign o_results    = result_count;
    assign o_refused    = refused_count;

    // divisor pair closest to the adjusted target, first strict minimum wins
    function automatic t_divisor_choice search_divisors(input logic [REQ_W-1:0] req,
                                                        input logic active,
                                                        input logic [DIV_W-1:0] src);
        longint unsigned s, rq, target, q, q_last, best_err, best_c, best_f;
        longint unsigned run_err, run_c, run_f, c, rate, err, achieved;
        t_divisor_choice r;
        r = '0;
        if (active) begin
            r.rejected = 1'b1;
            return r;
        end
        s  = 64'(src);
        rq = 64'(req);
        // quotient comes from the raw request and is not recomputed later
        if (rq == 0) begin
            target = 64'(FALLBACK_HZ);
            q      = 0;
        end else begin
            target = rq;
            q      = s / (PRESCALE * rq);
            if (q == 0) begin
                target = 64'(FALLBACK_HZ);
            end
        end
        if (target > CLAMP_HZ) begin
            target = 64'(CLAMP_HZ);
        end
        if (target <= FALLBACK_HZ && target > LOW_HZ) begin
            target = 64'(LOW_HZ);
        end
        q_last = (s % (PRESCALE * target) != 0) ? q + 1 : q;

        best_err = target;
        best_c   = 0;
        best_f   = 0;
        for (; q <= q_last; q++) begin
            run_err = target;
            run_c   = 0;
            run_f   = 0;
            for (int f = 0; f < FINE_STEPS; f++) begin
                c = q / longint'(f + 1);
                if (c != 0) begin
                    c = c - 1;
                end
                if (c > COARSE_MAX) begin
                    continue;
                end
                rate = s / (PRESCALE * (c + 1) * longint'(f + 1));
                err  = (rate > target) ? rate - target : target - rate;
                if (run_err > err) begin
                    run_c   = c;
                    run_f   = 64'(f);
                    run_err = err;
                end
            end
            if (run_err < best_err) begin
                best_err = run_err;
                best_c   = run_c;
                best_f   = run_f;
            end
        end
        achieved   = s / (PRESCALE * (best_c + 1) * (best_f + 1));
        r.coarse   = best_c[COARSE_W-1:0];
        r.fine     = best_f[FINE_W-1:0];
        r.achieved = achieved[RATE_W-1:0];
        r.error    = best_err[TGT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_divisor_choice oldest;
        if (!i_rst_n) begin
            source_hz <= SRC_RESET_HZ;
            choice_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                source_hz <= i_cfg_data;
            end
            if (i_start && !i_busy) begin
                choice_q.push_back(search_divisors(i_requested_hz, i_transfer_active,
                                                   source_hz));
            end
            if (i_strobe) begin
                if (choice_q.size() == 0) begin
                    $error("result with nothing outstanding");
                    fail_count++;
                end else begin
                    oldest = choice_q.pop_front();
                    result_count++;
                    if (oldest.rejected) begin
                        refused_count++;
                    end
                    if (i_rejected !== oldest.rejected) begin
                        $error("rejected: expected %0d, got %0d", oldest.rejected, i_rejected);
                        fail_count++;
                    end
                    if (i_coarse_divisor !== oldest.coarse) begin
                        $error("coarse_divisor: expected %0d, got %0d",
                               oldest.coarse, i_coarse_divisor);
                        fail_count++;
                    end
                    if (i_fine_divisor !== oldest.fine) begin
                        $error("fine_divisor: expected %0d, got %0d",
                               oldest.fine, i_fine_divisor);
                        fail_count++;
                    end
                    if (i_achieved_hz !== oldest.achieved) begin
                        $error("achieved_hz: expected %0d, got %0d",
                               oldest.achieved, i_achieved_hz);
                        fail_count++;
                    end
                    if (i_best_error_hz !== oldest.error) begin
                        $error("best_error_hz: expected %0d, got %0d",
                               oldest.error, i_best_error_hz);
                        fail_count++;
                    end
                end
            end
            o_pending <= choice_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2csd_pkg::*;

    localparam int FINE_STEPS = 64;
    localparam int COARSE_MAX = 3;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [REQ_W-1:0]    i_requested_hz;
    logic                i_transfer_active;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [DIV_W-1:0]    i_cfg_data;
    logic                o_strobe;
    logic                o_rejected;
    logic [COARSE_W-1:0] o_coarse_divisor;
    logic [FINE_W-1:0]   o_fine_divisor;
    logic [RATE_W-1:0]   o_achieved_hz;
    logic [TGT_W-1:0]    o_best_error_hz;

    int fail_count;
    int pending;
    int results;
    int refused;
    int source_writes = 0;
    bit gaps_on;

    i2c_scl_divisor_search #(
        .FINE_STEPS (FINE_STEPS),
        .COARSE_MAX (COARSE_MAX)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_requested_hz    (i_requested_hz),
        .i_transfer_active (i_transfer_active),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_rejected        (o_rejected),
        .o_coarse_divisor  (o_coarse_divisor),
        .o_fine_divisor    (o_fine_divisor),
        .o_achieved_hz     (o_achieved_hz),
        .o_best_error_hz   (o_best_error_hz)
    );

    // predicts and scores every result, we only drive and judge
    divisor_search_checker #(
        .FINE_STEPS (FINE_STEPS),
        .COARSE_MAX (COARSE_MAX)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_requested_hz    (i_requested_hz),
        .i_transfer_active (i_transfer_active),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_strobe          (o_strobe),
        .i_rejected        (o_rejected),
        .i_coarse_divisor  (o_coarse_divisor),
        .i_fine_divisor    (o_fine_divisor),
        .i_achieved_hz     (o_achieved_hz),
        .i_best_error_hz   (o_best_error_hz),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results         (results),
        .o_refused         (refused)
    );

    always #10 i_clk = ~i_clk;

    // some 120 searches need under 21 ms;
    // allow several times that
    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

    // present one request and hold it until the transfer; called and returning on a
    // rising edge. handshake signals are looked at on the falling edge, where they
    // are settled and cannot move before the next rising edge
    task automatic send_item(input logic [REQ_W-1:0] req, input logic active);
        int gap;
        i_requested_hz    <= req;
        i_transfer_active <= active;
        start             <= 1'b1;
        @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        // gap before the next item; with no gap start simply stays high
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register writes only once the block is idle and nothing is outstanding
    task automatic write_source(input logic [DIV_W-1:0] hz);
        start <= 1'b0;
        @(negedge i_clk);
        while (busy || pending != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= hz;
        @(negedge i_clk);
        while (!o_cfg_ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        source_writes++;
    endtask

    // bus rates biased towards realistic values and the adjustment edges
    function automatic logic [REQ_W-1:0] pick_rate(input logic [DIV_W-1:0] src);
        int unsigned top_rate;
        top_rate = src / 22;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return REQ_W'($urandom_range(1000, 400000));
            4:          return REQ_W'($urandom_range(89990, 100010));
            5:          return REQ_W'($urandom_range(384590, 384610));
            // just around the fallback threshold of source over 22
            6:          return (top_rate < 2) ? REQ_W'($urandom_range(0, 3))
                                              : REQ_W'(top_rate + $urandom_range(0, 4) - 2);
            7, 8:       return REQ_W'($urandom);
            default:    return REQ_W'($urandom_range(0, 1000));
        endcase
    endfunction

    initial begin
        logic [DIV_W-1:0] src;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_requested_hz    = '0;
        i_transfer_active = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = '0;
        gaps_on           = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset source clock of 100 MHz: zero request, the fallback threshold either
        // side, clamp, the 90..100 kHz band, a hopeless tiny rate where no coarse
        // value fits, and refusals while a transfer is active
        send_item(24'd0, 1'b0);
        send_item(24'd1, 1'b0);
        send_item(24'hFFFFFF, 1'b0);
        send_item(24'd4545454, 1'b0);
        send_item(24'd4545455, 1'b0);
        send_item(24'd384600, 1'b0);
        send_item(24'd384601, 1'b0);
        send_item(24'd400000, 1'b0);
        send_item(24'd100001, 1'b0);
        send_item(24'd100000, 1'b0);
        send_item(24'd95000, 1'b0);
        send_item(24'd90001, 1'b0);
        send_item(24'd90000, 1'b0);
        send_item(24'hFFFFFF, 1'b1);
        send_item(24'd0, 1'b1);

        // 22 MHz divides evenly by 22 x 250 kHz, so only one quotient is tried
        gaps_on = 1'b0;
        write_source(29'd22000000);
        send_item(24'd250000, 1'b0);
        send_item(24'd100000, 1'b0);

        // zero and minimum source clock: every rate collapses to nothing
        write_source(29'd0);
        send_item(24'd100000, 1'b0);
        send_item(24'd0, 1'b0);
        write_source(29'd1);
        send_item(24'd1, 1'b0);

        // fastest supported source clock
        write_source(29'd500000000);
        send_item(24'hFFFFFF, 1'b0);
        send_item(24'd400000, 1'b0);

        // random phases, each with its own source clock; idling alternates per phase
        for (int phase = 0; phase < 5; phase++) begin
            src = ($urandom_range(0, 9) < 7) ? DIV_W'($urandom_range(8000000, 200000000))
                                             : DIV_W'($urandom_range(1, 500000000));
            gaps_on = (phase % 2 == 0);
            write_source(src);
            for (int n = 0; n < 20; n++) begin
                send_item(pick_rate(src), $urandom_range(0, 9) == 0);
            end
        end

        start <= 1'b0;
        @(negedge i_clk);
        while (busy || pending != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("checked %0d results, %0d of them refused for an active transfer,",
                 results, refused);
        $display("across %0d source clock writes", source_writes);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- i2c_scl_divisor_search.f -----
+incdir+rtl
rtl/i2csd_pkg.sv
rtl/i2csd_div.sv
rtl/i2c_scl_divisor_search.sv
rtl/i2csd_chk.sv
dv/divisor_search_checker.sv
dv/tb.sv
